// ----- rtl/price_level_order_matcher_macros.svh -----
// Assertion macros for the order matcher.
`ifndef PRICE_LEVEL_ORDER_MATCHER_MACROS_SVH
`define PRICE_LEVEL_ORDER_MATCHER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define PLM_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define PLM_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/plm_pkg.sv -----
`default_nettype none

package plm_pkg;

  localparam int PRICE_W = 15;
  localparam int QTY_W   = 32;
  localparam int VOL_W   = 48;
  localparam int BID_W   = 14;
  localparam int ASK_W   = 15;
  localparam int BAR_W   = 14;

  // Classification made by the front end.
  typedef enum logic [1:0] {
    KIND_ORDER,
    KIND_NEWBAR,
    KIND_REJECT
  } plm_kind_t;

  // One queued beat.
  typedef struct packed {
    plm_kind_t          kind;
    logic               side;
    logic               mkt;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } plm_item_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_WALK_RD,
    ST_REST,
    ST_REST_RD,
    ST_ASK,
    ST_ASK_RD,
    ST_BID,
    ST_BID_RD,
    ST_OUT
  } plm_state_t;

endpackage

`default_nettype wire

// ----- rtl/plm_front.sv -----
`default_nettype none

module plm_front #(
  parameter int PRICE_LEVELS = 16384
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         op,
  input  wire logic                         side,
  input  wire logic                         order_type,
  input  wire logic [plm_pkg::PRICE_W-1:0]  price,
  input  wire logic [plm_pkg::QTY_W-1:0]    quantity,
  output logic                              q_valid,
  output plm_pkg::plm_item_t                q_item,
  input  wire logic                         q_pop
);

  localparam int QD = 2;

  plm_pkg::plm_item_t entries [QD];
  plm_pkg::plm_item_t item_in;
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;

  // Classify the incoming beat.
  always_comb begin
    item_in.side  = side;
    item_in.mkt   = order_type;
    item_in.price = price;
    item_in.qty   = quantity;
    if (op) begin
      item_in.kind = plm_pkg::KIND_NEWBAR;
    end else if (!order_type && (32'(price) >= 32'(PRICE_LEVELS))) begin
      item_in.kind = plm_pkg::KIND_REJECT;
    end else begin
      item_in.kind = plm_pkg::KIND_ORDER;
    end
  end

  assign in_stall = (count == 2'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  // Two-entry queue to the back end.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/plm_engine.sv -----
`default_nettype none

module plm_engine #(
  parameter int PRICE_LEVELS = 16384,
  parameter int LEVEL_WIDTH  = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire plm_pkg::plm_item_t          q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             rejected,
  output logic [plm_pkg::QTY_W-1:0]        filled_qty,
  output logic [plm_pkg::QTY_W-1:0]        rested_qty,
  output logic [plm_pkg::BID_W-1:0]        bid_level,
  output logic [plm_pkg::ASK_W-1:0]        ask_level,
  output logic [plm_pkg::BAR_W-1:0]        bar_open,
  output logic [plm_pkg::BAR_W-1:0]        bar_high,
  output logic [plm_pkg::BAR_W-1:0]        bar_low,
  output logic [plm_pkg::BAR_W-1:0]        bar_close,
  output logic [plm_pkg::VOL_W-1:0]        bar_volume,
  output logic                             bar_has_trades
);

  localparam int AW  = $clog2(PRICE_LEVELS);
  localparam int LVW = AW + 1;
  localparam int CW  = (LEVEL_WIDTH > 32) ? LEVEL_WIDTH : 32;
  localparam int QW  = plm_pkg::QTY_W;
  localparam int VW  = plm_pkg::VOL_W;
  localparam logic [LVW-1:0]         PL_L      = LVW'(PRICE_LEVELS);
  localparam logic [AW-1:0]          LAST_ADDR = AW'(PRICE_LEVELS - 1);
  localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;
  localparam logic [VW-1:0]          VOL_MAX   = '1;

  // Level totals, one memory per side.
  logic [LEVEL_WIDTH-1:0] ask_mem [PRICE_LEVELS];
  logic [LEVEL_WIDTH-1:0] bid_mem [PRICE_LEVELS];
  logic [LEVEL_WIDTH-1:0] ask_q, bid_q, mem_rdata;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [LEVEL_WIDTH-1:0] wr_data;
  logic                   we_ask, we_bid;

  plm_pkg::plm_state_t state, state_next;
  plm_pkg::plm_item_t  cur, cur_next;
  logic [AW-1:0]       clr_addr, clr_addr_next;
  logic [LVW-1:0]      lvl, lvl_next;
  logic [QW-1:0]       rem, rem_next;
  logic [QW-1:0]       filled, filled_next;
  logic [QW-1:0]       rested, rested_next;
  logic                rej, rej_next;
  logic                rd_sel, rd_sel_next;
  logic [AW-1:0]       bb, bb_next;
  logic [LVW-1:0]      ba, ba_next;
  logic [AW-1:0]       open_p, open_next, high_p, high_next;
  logic [AW-1:0]       low_p, low_next, close_p, close_next;
  logic [VW-1:0]       vol, vol_next;
  logic                active, active_next;

  logic [CW-1:0]       avail_ext, left;
  logic [QW-1:0]       take;
  logic [CW:0]         rest_sum;
  logic [VW:0]         vol_sum;
  logic                walk_stop;
  logic [AW-1:0]       fill_lvl;

  always_ff @(posedge clk) begin
    if (we_ask) ask_mem[wr_addr] <= wr_data;
    if (we_bid) bid_mem[wr_addr] <= wr_data;
    ask_q <= ask_mem[rd_addr];
    bid_q <= bid_mem[rd_addr];
  end

  assign mem_rdata = rd_sel ? bid_q : ask_q;

  // Fill and rest arithmetic.
  always_comb begin
    avail_ext = CW'(mem_rdata);
    take      = (avail_ext >= CW'(rem)) ? rem : QW'(mem_rdata);
    left      = avail_ext - CW'(take);
    rest_sum  = (CW+1)'(mem_rdata) + (CW+1)'(rem);
    vol_sum   = (VW+1)'(vol) + (VW+1)'(take);
    fill_lvl  = lvl[AW-1:0];
    walk_stop = (rem == '0) || (lvl == '0) || (lvl >= PL_L) ||
                (!cur.mkt && !cur.side && (32'(lvl) > 32'(cur.price))) ||
                (!cur.mkt && cur.side && (32'(lvl) < 32'(cur.price)));
  end

  // Sequencer.
  always_comb begin
    state_next    = state;
    cur_next      = cur;
    clr_addr_next = clr_addr;
    lvl_next      = lvl;
    rem_next      = rem;
    filled_next   = filled;
    rested_next   = rested;
    rej_next      = rej;
    rd_sel_next   = rd_sel;
    bb_next       = bb;
    ba_next       = ba;
    open_next     = open_p;
    high_next     = high_p;
    low_next      = low_p;
    close_next    = close_p;
    vol_next      = vol;
    active_next   = active;
    q_pop         = 1'b0;
    rd_addr       = '0;
    wr_addr       = '0;
    wr_data       = '0;
    we_ask        = 1'b0;
    we_bid        = 1'b0;
    case (state)
      plm_pkg::ST_CLEAR: begin
        we_ask        = 1'b1;
        we_bid        = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) state_next = plm_pkg::ST_IDLE;
      end
      plm_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cur_next    = q_item;
          filled_next = '0;
          rested_next = '0;
          rej_next    = 1'b0;
          rem_next    = q_item.qty;
          lvl_next    = q_item.side ? LVW'(bb) : ba;
          case (q_item.kind)
            plm_pkg::KIND_NEWBAR: begin
              open_next   = '0;
              high_next   = '0;
              low_next    = '0;
              close_next  = '0;
              vol_next    = '0;
              active_next = 1'b0;
              state_next  = plm_pkg::ST_OUT;
            end
            plm_pkg::KIND_REJECT: begin
              rej_next   = 1'b1;
              state_next = plm_pkg::ST_OUT;
            end
            default: state_next = plm_pkg::ST_WALK;
          endcase
        end
      end
      plm_pkg::ST_WALK: begin
        if (walk_stop) begin
          state_next = plm_pkg::ST_REST;
        end else begin
          rd_addr     = lvl[AW-1:0];
          rd_sel_next = cur.side;
          state_next  = plm_pkg::ST_WALK_RD;
        end
      end
      plm_pkg::ST_WALK_RD: begin
        if (mem_rdata != '0) begin
          wr_addr     = fill_lvl;
          wr_data     = LEVEL_WIDTH'(left);
          we_ask      = !cur.side;
          we_bid      = cur.side;
          rem_next    = rem - take;
          filled_next = filled + take;
          close_next  = fill_lvl;
          active_next = 1'b1;
          if (!active) begin
            open_next = fill_lvl;
            high_next = fill_lvl;
            low_next  = fill_lvl;
            vol_next  = VW'(take);
          end else begin
            if (fill_lvl > high_p) high_next = fill_lvl;
            if (fill_lvl < low_p) low_next = fill_lvl;
            vol_next = vol_sum[VW] ? VOL_MAX : vol_sum[VW-1:0];
          end
        end
        lvl_next   = cur.side ? (lvl - 1'b1) : (lvl + 1'b1);
        state_next = plm_pkg::ST_WALK;
      end
      plm_pkg::ST_REST: begin
        // A limit order moves its own side's best price to its price when that side is empty or the price is better.
        rested_next = cur.mkt ? '0 : rem;
        state_next  = plm_pkg::ST_ASK;
        if (!cur.mkt) begin
          if (!cur.side) begin
            if (bb == '0 || AW'(cur.price) > bb) bb_next = AW'(cur.price);
          end else begin
            if (ba == PL_L || LVW'(cur.price) < ba) ba_next = LVW'(cur.price);
          end
          if (rem != '0) begin
            rd_addr     = AW'(cur.price);
            rd_sel_next = !cur.side;
            state_next  = plm_pkg::ST_REST_RD;
          end
        end
      end
      plm_pkg::ST_REST_RD: begin
        wr_addr    = AW'(cur.price);
        wr_data    = (rest_sum > (CW+1)'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_WIDTH'(rest_sum);
        we_ask     = cur.side;
        we_bid     = !cur.side;
        state_next = plm_pkg::ST_ASK;
      end
      plm_pkg::ST_ASK: begin
        if (ba < PL_L) begin
          rd_addr     = ba[AW-1:0];
          rd_sel_next = 1'b0;
          state_next  = plm_pkg::ST_ASK_RD;
        end else begin
          state_next = plm_pkg::ST_BID;
        end
      end
      plm_pkg::ST_ASK_RD: begin
        if (mem_rdata == '0) begin
          ba_next    = ba + 1'b1;
          state_next = plm_pkg::ST_ASK;
        end else begin
          state_next = plm_pkg::ST_BID;
        end
      end
      plm_pkg::ST_BID: begin
        if (bb != '0) begin
          rd_addr     = bb;
          rd_sel_next = 1'b1;
          state_next  = plm_pkg::ST_BID_RD;
        end else begin
          state_next = plm_pkg::ST_OUT;
        end
      end
      plm_pkg::ST_BID_RD: begin
        if (mem_rdata == '0) begin
          bb_next    = bb - 1'b1;
          state_next = plm_pkg::ST_BID;
        end else begin
          state_next = plm_pkg::ST_OUT;
        end
      end
      plm_pkg::ST_OUT: begin
        if (!out_stall) state_next = plm_pkg::ST_IDLE;
      end
      default: state_next = plm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= plm_pkg::ST_CLEAR;
      clr_addr <= '0;
      bb       <= '0;
      ba       <= PL_L;
      open_p   <= '0;
      high_p   <= '0;
      low_p    <= '0;
      close_p  <= '0;
      vol      <= '0;
      active   <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      bb       <= bb_next;
      ba       <= ba_next;
      open_p   <= open_next;
      high_p   <= high_next;
      low_p    <= low_next;
      close_p  <= close_next;
      vol      <= vol_next;
      active   <= active_next;
    end
  end

  // Per-order working registers.
  always_ff @(posedge clk) begin
    cur    <= cur_next;
    lvl    <= lvl_next;
    rem    <= rem_next;
    filled <= filled_next;
    rested <= rested_next;
    rej    <= rej_next;
    rd_sel <= rd_sel_next;
  end

  assign out_valid      = (state == plm_pkg::ST_OUT);
  assign rejected       = rej;
  assign filled_qty     = filled;
  assign rested_qty     = rested;
  assign bid_level      = plm_pkg::BID_W'(bb);
  assign ask_level      = plm_pkg::ASK_W'(ba);
  assign bar_open       = plm_pkg::BAR_W'(open_p);
  assign bar_high       = plm_pkg::BAR_W'(high_p);
  assign bar_low        = plm_pkg::BAR_W'(low_p);
  assign bar_close      = plm_pkg::BAR_W'(close_p);
  assign bar_volume     = vol;
  assign bar_has_trades = active;

endmodule

`default_nettype wire

// ----- rtl/price_level_order_matcher.sv -----
// Sequence: new-bar and rejected beats go straight to the result; orders walk the
// opposite side level by level while matching, rest any limit remainder, then resync
// the best ask and best bid by skipping empty levels before the result is shown.
// Throughput: one beat at a time in the back-end sequencer; the 2-entry front queue
// keeps taking beats while a result waits. Rate is set by the one-read memory walk.
// Reset: synchronous, active high; afterwards both level memories are cleared level by
// level before the first beat is processed.
`default_nettype none

`include "price_level_order_matcher_macros.svh"

module price_level_order_matcher #(
  parameter int PRICE_LEVELS = 16384,
  parameter int LEVEL_WIDTH  = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        op,
  input  wire logic                        side,
  input  wire logic                        order_type,
  input  wire logic [plm_pkg::PRICE_W-1:0] price,
  input  wire logic [plm_pkg::QTY_W-1:0]   quantity,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             rejected,
  output logic [plm_pkg::QTY_W-1:0]        filled_qty,
  output logic [plm_pkg::QTY_W-1:0]        rested_qty,
  output logic [plm_pkg::BID_W-1:0]        bid_level,
  output logic [plm_pkg::ASK_W-1:0]        ask_level,
  output logic [plm_pkg::BAR_W-1:0]        bar_open,
  output logic [plm_pkg::BAR_W-1:0]        bar_high,
  output logic [plm_pkg::BAR_W-1:0]        bar_low,
  output logic [plm_pkg::BAR_W-1:0]        bar_close,
  output logic [plm_pkg::VOL_W-1:0]        bar_volume,
  output logic                             bar_has_trades
);

  logic               q_valid;
  logic               q_pop;
  plm_pkg::plm_item_t q_item;

  plm_front #(.PRICE_LEVELS(PRICE_LEVELS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .op, .side, .order_type, .price, .quantity,
    .q_valid, .q_item, .q_pop
  );

  plm_engine #(.PRICE_LEVELS(PRICE_LEVELS), .LEVEL_WIDTH(LEVEL_WIDTH)) u_engine (
    .clk, .rst, .q_valid, .q_item, .q_pop, .out_valid, .out_stall,
    .rejected, .filled_qty, .rested_qty, .bid_level, .ask_level,
    .bar_open, .bar_high, .bar_low, .bar_close, .bar_volume, .bar_has_trades
  );

  `PLM_ASSERT_IMP(a_pop_needs_item, q_pop, q_valid, "queue popped while empty")
  `PLM_ASSERT_IMP(a_no_pop_in_out, out_valid, !q_pop, "queue popped while a result waits")
  `PLM_ASSERT_IMP(a_reject_empty, out_valid && rejected,
                  filled_qty == '0 && rested_qty == '0, "rejected beat moved quantity")
  `PLM_ASSERT_NEXT(a_out_taken, out_valid && !out_stall, !out_valid,
                   "result repeated after it was taken")

endmodule

`default_nettype wire

// ----- tb/plm_checker.sv -----
`default_nettype none

module plm_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic                        op,
  input  wire logic                        side,
  input  wire logic                        order_type,
  input  wire logic [plm_pkg::PRICE_W-1:0] price,
  input  wire logic [plm_pkg::QTY_W-1:0]   quantity,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic                        rejected,
  input  wire logic [plm_pkg::QTY_W-1:0]   filled_qty,
  input  wire logic [plm_pkg::QTY_W-1:0]   rested_qty,
  input  wire logic [plm_pkg::BID_W-1:0]   bid_level,
  input  wire logic [plm_pkg::ASK_W-1:0]   ask_level,
  input  wire logic [plm_pkg::BAR_W-1:0]   bar_open,
  input  wire logic [plm_pkg::BAR_W-1:0]   bar_high,
  input  wire logic [plm_pkg::BAR_W-1:0]   bar_low,
  input  wire logic [plm_pkg::BAR_W-1:0]   bar_close,
  input  wire logic [plm_pkg::VOL_W-1:0]   bar_volume,
  input  wire logic                        bar_has_trades,
  output int                               mismatches,
  output int                               pending
);

  localparam int NLEV = 16384;
  localparam longint unsigned LEVEL_MAX = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned VOL_MAX   = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic                        rej;
    logic [plm_pkg::QTY_W-1:0]   filled;
    logic [plm_pkg::QTY_W-1:0]   rested;
    logic [plm_pkg::BID_W-1:0]   bid;
    logic [plm_pkg::ASK_W-1:0]   ask;
    logic [plm_pkg::BAR_W-1:0]   open_px;
    logic [plm_pkg::BAR_W-1:0]   high_px;
    logic [plm_pkg::BAR_W-1:0]   low_px;
    logic [plm_pkg::BAR_W-1:0]   close_px;
    logic [plm_pkg::VOL_W-1:0]   vol;
    logic                        traded;
  } book_report_t;

  // Shadow book and bar
  longint unsigned ask_lv[NLEV];
  longint unsigned bid_lv[NLEV];
  int              top_ask, top_bid;
  int              o_px, h_px, l_px, c_px;
  longint unsigned bar_vol;
  bit              bar_live;

  book_report_t report_q[$];

  function automatic void clear_bar();
    o_px = 0; h_px = 0; l_px = 0; c_px = 0; bar_vol = 0; bar_live = 0;
  endfunction

  function automatic void record_fill(int lvl, longint unsigned qty);
    if (!bar_live) begin
      o_px = lvl; h_px = lvl; l_px = lvl; c_px = lvl;
      bar_vol = qty; bar_live = 1;
    end else begin
      if (lvl > h_px) h_px = lvl;
      if (lvl < l_px) l_px = lvl;
      c_px = lvl;
      bar_vol = (qty > VOL_MAX - bar_vol) ? VOL_MAX : bar_vol + qty;
    end
  endfunction

  // Apply one beat to the shadow book and return the report it should produce
  function automatic book_report_t match_order(bit is_bar, bit sell, bit mkt,
                                               int px, longint unsigned qty);
    book_report_t r;
    int lvl;
    longint unsigned rem, avail, f, cur, filled, rested;
    bit rej;
    rej = 0; filled = 0; rested = 0;
    if (is_bar) begin
      clear_bar();
    end else if (!mkt && px >= NLEV) begin
      rej = 1;
    end else begin
      lvl = sell ? top_bid : top_ask;
      rem = qty;
      while (rem > 0) begin
        if (lvl == 0 || lvl >= NLEV) break;
        if (!mkt && !sell && lvl > px) break;
        if (!mkt && sell && lvl < px) break;
        avail = sell ? bid_lv[lvl] : ask_lv[lvl];
        if (avail > 0) begin
          f = (avail >= rem) ? rem : avail;
          if (sell) bid_lv[lvl] = avail - f;
          else ask_lv[lvl] = avail - f;
          rem -= f;
          filled += f;
          record_fill(lvl, f);
        end
        lvl = sell ? lvl - 1 : lvl + 1;
      end
      // limit orders rest the remainder and always touch their own best price
      if (!mkt) begin
        if (rem > 0) begin
          cur = sell ? ask_lv[px] : bid_lv[px];
          cur = (rem > LEVEL_MAX - cur) ? LEVEL_MAX : cur + rem;
          if (sell) ask_lv[px] = cur;
          else bid_lv[px] = cur;
          rested = rem;
        end
        if (!sell) begin
          if (top_bid == 0 || px > top_bid) top_bid = px;
        end else begin
          if (top_ask == NLEV || px < top_ask) top_ask = px;
        end
      end
      while (top_ask < NLEV && ask_lv[top_ask] == 0) top_ask++;
      while (top_bid > 0 && top_bid < NLEV && bid_lv[top_bid] == 0) top_bid--;
    end
    r.rej      = rej;
    r.filled   = filled[plm_pkg::QTY_W-1:0];
    r.rested   = rested[plm_pkg::QTY_W-1:0];
    r.bid      = top_bid[plm_pkg::BID_W-1:0];
    r.ask      = top_ask[plm_pkg::ASK_W-1:0];
    r.open_px  = o_px[plm_pkg::BAR_W-1:0];
    r.high_px  = h_px[plm_pkg::BAR_W-1:0];
    r.low_px   = l_px[plm_pkg::BAR_W-1:0];
    r.close_px = c_px[plm_pkg::BAR_W-1:0];
    r.vol      = bar_vol[plm_pkg::VOL_W-1:0];
    r.traded   = bar_live;
    return r;
  endfunction

  // Watch both channels: predict on input beats, compare on output beats
  always @(posedge clk) begin
    book_report_t want, got;
    if (rst) begin
      for (int i = 0; i < NLEV; i++) begin
        ask_lv[i] = 0;
        bid_lv[i] = 0;
      end
      top_ask = NLEV; top_bid = 0;
      clear_bar();
      report_q.delete();
      mismatches <= 0;
    end else begin
      if (in_valid && !in_stall)
        report_q.push_back(match_order(op, side, order_type, int'(price),
                                       longint'(quantity)));
      if (out_valid && !out_stall) begin
        got = '{rejected, filled_qty, rested_qty, bid_level, ask_level, bar_open,
                bar_high, bar_low, bar_close, bar_volume, bar_has_trades};
        if (report_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat: %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = report_q.pop_front();
          if (want !== got) begin
            if (mismatches < 10) begin
              $display("mismatch rej %0d/%0d fill %0h/%0h rest %0h/%0h bid %0d/%0d ask %0d/%0d",
                       want.rej, got.rej, want.filled, got.filled, want.rested,
                       got.rested, want.bid, got.bid, want.ask, got.ask);
              $display("  bar o %0d/%0d h %0d/%0d l %0d/%0d c %0d/%0d v %0h/%0h t %0d/%0d",
                       want.open_px, got.open_px, want.high_px, got.high_px,
                       want.low_px, got.low_px, want.close_px, got.close_px,
                       want.vol, got.vol, want.traded, got.traded);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    pending <= report_q.size();
  end

endmodule

`default_nettype wire

// ----- tb/tb_price_level_order_matcher.sv -----
`default_nettype none

module tb_price_level_order_matcher;

  localparam int NLEV     = 16384;
  localparam int N_RANDOM = 2000;
  localparam int IDLE_MAX = 500000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic op = 0, side = 0, order_type = 0;
  logic [plm_pkg::PRICE_W-1:0] price = '0;
  logic [plm_pkg::QTY_W-1:0]   quantity = '0;
  logic out_stall = 0;

  logic in_stall, out_valid, rejected, bar_has_trades;
  logic [plm_pkg::QTY_W-1:0] filled_qty, rested_qty;
  logic [plm_pkg::BID_W-1:0] bid_level;
  logic [plm_pkg::ASK_W-1:0] ask_level;
  logic [plm_pkg::BAR_W-1:0] bar_open, bar_high, bar_low, bar_close;
  logic [plm_pkg::VOL_W-1:0] bar_volume;

  int mismatches, pending;
  int beats_sent = 0;
  int idle_cycles = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  price_level_order_matcher u_dut (.*);

  plm_checker u_chk (.*);

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one beat and hold it until accepted
  task automatic offer(bit is_bar, bit sell, bit mkt, int px, longint unsigned qty);
    bit stalled;
    in_valid   <= 1;
    op         <= is_bar;
    side       <= sell;
    order_type <= mkt;
    price      <= px[plm_pkg::PRICE_W-1:0];
    quantity   <= qty[plm_pkg::QTY_W-1:0];
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    beats_sent++;
  endtask

  task automatic random_order();
    bit is_bar, sell, mkt;
    int px, pick;
    longint unsigned qty;
    is_bar = ($urandom_range(99) < 5);
    sell   = 1'($urandom_range(1));
    mkt    = ($urandom_range(99) < 15);
    if (mkt) px = $urandom_range(32767);
    else if ($urandom_range(99) < 3) px = $urandom_range(32767, NLEV);
    else px = $urandom_range(310, 90);
    pick = $urandom_range(99);
    if (pick < 70) qty = 64'($urandom_range(500, 1));
    else if (pick < 90) qty = 64'($urandom_range(5000));
    else if (pick < 98) qty = 0;
    else qty = 64'($urandom);
    if (is_bar) begin
      sell = 1'($urandom_range(1)); mkt = 1'($urandom_range(1));
      px = $urandom_range(32767); qty = 64'($urandom);
    end
    offer(is_bar, sell, mkt, px, qty);
  endtask

  // Sender: directed beats, then random bursts with gaps
  initial begin
    int burst;
    repeat (4) @(posedge clk);
    rst <= 0;
    // deep anchors keep resync walks short
    repeat (5) offer(0, 1, 0, 320, 64'hFFFF_FFFF);
    repeat (5) offer(0, 0, 0, 80, 64'hFFFF_FFFF);
    offer(1, 1, 1, 32767, 64'hFFFF_FFFF);
    offer(0, 0, 0, NLEV, 10);
    offer(0, 1, 0, 32767, 10);
    offer(0, 0, 1, 32767, 25);
    offer(0, 0, 0, 200, 100);
    offer(0, 1, 0, 150, 300);
    offer(0, 0, 0, 310, 0);
    offer(0, 0, 0, NLEV - 1, 0);
    offer(0, 1, 0, NLEV - 1, 5);
    offer(0, 1, 1, 0, 50);
    offer(1, 0, 0, 0, 0);
    while (beats_sent < N_RANDOM + 21) begin
      burst = $urandom_range(20, 1);
      repeat (burst) random_order();
      if ($urandom_range(9) < 7) begin
        in_valid <= 0;
        repeat ($urandom_range(10, 1)) @(posedge clk);
      end
    end
    // level zero: a bid may rest there, an ask there pins the best ask
    offer(0, 0, 0, 0, 7);
    offer(0, 1, 0, 0, 3);
    repeat (10) random_order();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: stall phases of varying density, plus one long hold-off
  initial begin
    bit held;
    int pct;
    held = 0;
    forever begin
      if (!held && beats_sent >= 700) begin
        held = 1;
        out_stall <= 1;
        repeat (500) @(posedge clk);
      end
      pct = $urandom_range(2) * 40;
      repeat ($urandom_range(200, 50)) begin
        out_stall <= ($urandom_range(99) < pct);
        @(posedge clk);
      end
    end
  end

endmodule

`default_nettype wire
